// ===== sv/sms_pkg.sv =====
// ----------------------------------------------------------------------------
// sms_pkg
// Shared types and sizes for the stack machine instruction step block.
// ----------------------------------------------------------------------------
package sms_pkg;

  localparam int STACK_DEPTH = 256;
  localparam int WORD_BITS   = 8;

  localparam int SAW  = $clog2(STACK_DEPTH);
  localparam int SDW  = $clog2(STACK_DEPTH + 1);
  localparam int CMPW = (SDW > 9) ? SDW : 9;

  localparam int IP_W   = 9;
  localparam int OP_W   = 4;
  localparam int ARG_W  = 8;
  localparam int ST_W   = 4;
  localparam int PLEN_W = 9;
  localparam int CHAR_W = 8;

  localparam int OUTQ_DEPTH = 3;
  localparam int QPW        = $clog2(OUTQ_DEPTH);
  localparam int QCW        = $clog2(OUTQ_DEPTH + 1);

  typedef enum logic [OP_W-1:0] {
    OP_PUSH  = 4'd0,
    OP_ADD   = 4'd1,
    OP_SUB   = 4'd2,
    OP_GT    = 4'd3,
    OP_LT    = 4'd4,
    OP_JMP   = 4'd5,
    OP_JNZ   = 4'd6,
    OP_JZ    = 4'd7,
    OP_DUP   = 4'd8,
    OP_POP   = 4'd9,
    OP_HALT  = 4'd10,
    OP_WRITE = 4'd11,
    OP_SWAP  = 4'd12,
    OP_CALL  = 4'd13,
    OP_RET   = 4'd14
  } op_e;

  typedef enum logic [ST_W-1:0] {
    ST_OK         = 4'd0,
    ST_BAD_OP     = 4'd1,
    ST_OVERFLOW   = 4'd2,
    ST_UNDERFLOW  = 4'd3,
    ST_BAD_JUMP   = 4'd4,
    ST_BAD_ARG    = 4'd5,
    ST_BAD_CALL   = 4'd6,
    ST_CALL_OVER  = 4'd7,
    ST_CALL_UNDER = 4'd8
  } status_e;

  typedef struct packed {
    status_e             status;
    logic [IP_W-1:0]     next_ip;
    logic                halted;
    logic                char_valid;
    logic [CHAR_W-1:0]   char_out;
  } result_t;

endpackage

// ===== sv/stack_machine_instruction_step.sv =====
// ----------------------------------------------------------------------------
// stack_machine_instruction_step
// Executes one byte stack machine instruction per beat.
//
//   channel  | direction | handshake               | payload
//   ---------+-----------+-------------------------+-----------------------------
//   in       | in        | in_valid_i / in_stall_o | op_i, operand_i
//   out      | out       | out_valid_o/out_stall_i | status_o, next_ip_o,
//            |           |                         | halted_flag_o, char_valid_o,
//            |           |                         | char_out_o
//   config   | in        | cfg_we_i                | cfg_wdata_i (program_length)
//
// One instruction per cycle while in_stall_o is low; results are queued.
// Depths and status resolve in the accept cycle, which issues the stack
// memory reads; the next cycle takes the read data, updates the top-of-stack
// and ip registers and writes the memories, with a bypass for a same-entry
// write. A three-entry result queue absorbs output stalls; in_stall_o rises
// when it could overflow. Reset clears depths, ip, halt flag and length
// and needs no memory clearing.
// ----------------------------------------------------------------------------
module stack_machine_instruction_step
  import sms_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_we_i,
  input  logic [PLEN_W-1:0] cfg_wdata_i,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  logic [OP_W-1:0]   op_i,
  input  logic [ARG_W-1:0]  operand_i,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output logic [ST_W-1:0]   status_o,
  output logic [IP_W-1:0]   next_ip_o,
  output logic              halted_flag_o,
  output logic              char_valid_o,
  output logic [CHAR_W-1:0] char_out_o
);

  // architectural state
  logic [PLEN_W-1:0]    plen_q;
  logic [SDW-1:0]       dep_q, dep_d;
  logic [SDW-1:0]       rdep_q, rdep_d;
  logic [IP_W-1:0]      ip_q, ip_d;
  logic                 halt_q, halt_d;
  logic [WORD_BITS-1:0] tos_q, tos_d;

  // execute stage
  logic                 s2_v_q;
  op_e                  s2_op_q;
  logic [ARG_W-1:0]     s2_arg_q;
  status_e              s2_st_q;
  logic                 s2_kz_q;
  logic                 s2_dwe_q;
  logic [SAW-1:0]       s2_dwa_q;
  logic                 s2_rwe_q;
  logic [SAW-1:0]       s2_rwa_q;
  logic                 s2_dhit_q;
  logic [WORD_BITS-1:0] s2_dbyp_q;
  logic                 s2_rhit_q;
  logic [IP_W-1:0]      s2_rbyp_q;

  // decode stage
  logic                 acc;
  status_e              st;
  logic                 dwe, rwe;
  logic [SAW-1:0]       dwa, dra, rwa, rra;
  logic [CMPW-1:0]      dep_x, arg_x, top_x, sec_x, deep_x;
  logic [SDW-1:0]       rdm1;
  logic                 tgt_bad;

  // memory ports
  logic [WORD_BITS-1:0] d_rdata;
  logic [IP_W-1:0]      r_rdata;
  logic [WORD_BITS-1:0] rd_data;
  logic [IP_W-1:0]      rr_data;
  logic [IP_W-1:0]      ip_inc;
  logic                 cv;
  logic                 ok;
  logic                 taken;

  logic [QCW-1:0]       q_cnt;
  logic [QCW:0]         occ;
  result_t              res, q_data;

  assign occ        = {1'b0, q_cnt} + {{QCW{1'b0}}, s2_v_q};
  assign in_stall_o = (occ >= (QCW + 1)'(OUTQ_DEPTH));
  assign acc        = in_valid_i && !in_stall_o;

  assign dep_x   = CMPW'(dep_q);
  assign arg_x   = CMPW'(operand_i);
  assign top_x   = dep_x - CMPW'(1);
  assign sec_x   = dep_x - CMPW'(2);
  assign deep_x  = dep_x - arg_x - CMPW'(1);
  assign rdm1    = rdep_q - SDW'(1);
  assign tgt_bad = ({1'b0, operand_i} >= plen_q);

  always_comb begin
    st     = ST_OK;
    dep_d  = dep_q;
    rdep_d = rdep_q;
    dwe    = 1'b0;
    dwa    = top_x[SAW-1:0];
    dra    = sec_x[SAW-1:0];
    rwe    = 1'b0;
    rwa    = rdep_q[SAW-1:0];
    rra    = rdm1[SAW-1:0];
    case (op_e'(op_i))
      OP_PUSH: begin
        if (dep_q == SDW'(STACK_DEPTH)) begin
          st = ST_OVERFLOW;
        end else begin
          dep_d = dep_q + SDW'(1);
          dwe   = (dep_q != '0);
        end
      end
      OP_ADD, OP_SUB, OP_GT, OP_LT: begin
        if (dep_q < SDW'(2)) begin
          st = ST_UNDERFLOW;
        end else begin
          dep_d = dep_q - SDW'(1);
        end
      end
      OP_JMP: begin
        if (tgt_bad) begin
          st = ST_BAD_JUMP;
        end
      end
      OP_JNZ, OP_JZ: begin
        if (tgt_bad) begin
          st = ST_BAD_JUMP;
        end else if (dep_q == '0) begin
          st = ST_UNDERFLOW;
        end
      end
      OP_DUP: begin
        dra = deep_x[SAW-1:0];
        if (arg_x >= dep_x) begin
          st = ST_BAD_ARG;
        end else if (dep_q == SDW'(STACK_DEPTH)) begin
          st = ST_OVERFLOW;
        end else begin
          dep_d = dep_q + SDW'(1);
          dwe   = 1'b1;
        end
      end
      OP_POP: begin
        if (dep_q == '0) begin
          st = ST_UNDERFLOW;
        end else begin
          dep_d = dep_q - SDW'(1);
        end
      end
      OP_HALT: begin
        st = ST_OK;
      end
      OP_WRITE: begin
        if (dep_q == '0) begin
          st = ST_UNDERFLOW;
        end
      end
      OP_SWAP: begin
        dra = deep_x[SAW-1:0];
        dwa = deep_x[SAW-1:0];
        if (dep_q == '0 || arg_x >= dep_x) begin
          st = ST_BAD_ARG;
        end else begin
          dwe = (operand_i != '0);
        end
      end
      OP_CALL: begin
        if (tgt_bad) begin
          st = ST_BAD_CALL;
        end else if (rdep_q == SDW'(STACK_DEPTH)) begin
          st = ST_CALL_OVER;
        end else begin
          rdep_d = rdep_q + SDW'(1);
          rwe    = 1'b1;
        end
      end
      OP_RET: begin
        if (rdep_q == '0) begin
          st = ST_CALL_UNDER;
        end else begin
          rdep_d = rdm1;
        end
      end
      default: begin
        st = ST_BAD_OP;
      end
    endcase
  end

  // execute: read data arrives, registers and memories update
  assign rd_data = s2_dhit_q ? s2_dbyp_q : d_rdata;
  assign rr_data = s2_rhit_q ? s2_rbyp_q : r_rdata;
  assign ip_inc  = ip_q + IP_W'(1);
  assign ok      = (s2_st_q == ST_OK);
  assign taken   = ((s2_op_q == OP_JNZ) == (tos_q != '0));

  always_comb begin
    tos_d  = tos_q;
    ip_d   = ip_q;
    halt_d = halt_q;
    cv     = 1'b0;
    if (s2_v_q && ok) begin
      ip_d = ip_inc;
      case (s2_op_q)
        OP_PUSH:  tos_d = WORD_BITS'(s2_arg_q);
        OP_ADD:   tos_d = rd_data + tos_q;
        OP_SUB:   tos_d = rd_data - tos_q;
        OP_GT:    tos_d = WORD_BITS'(rd_data > tos_q);
        OP_LT:    tos_d = WORD_BITS'(rd_data < tos_q);
        OP_JMP:   ip_d  = IP_W'(s2_arg_q);
        OP_JNZ, OP_JZ: begin
          if (taken) begin
            ip_d = IP_W'(s2_arg_q);
          end
        end
        OP_DUP:   tos_d = s2_kz_q ? tos_q : rd_data;
        OP_POP:   tos_d = rd_data;
        OP_HALT:  halt_d = 1'b1;
        OP_WRITE: cv = 1'b1;
        OP_SWAP: begin
          if (!s2_kz_q) begin
            tos_d = rd_data;
          end
        end
        OP_CALL:  ip_d = IP_W'(s2_arg_q);
        OP_RET:   ip_d = rr_data;
        default:  cv = 1'b0;
      endcase
    end
  end

  always_comb begin
    res.status     = s2_st_q;
    res.next_ip    = ip_d;
    res.halted     = halt_d;
    res.char_valid = cv;
    res.char_out   = cv ? tos_q[CHAR_W-1:0] : '0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      plen_q <= '0;
      dep_q  <= '0;
      rdep_q <= '0;
      ip_q   <= '0;
      halt_q <= 1'b0;
      s2_v_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        plen_q <= cfg_wdata_i;
      end
      if (acc) begin
        dep_q  <= dep_d;
        rdep_q <= rdep_d;
      end
      ip_q   <= ip_d;
      halt_q <= halt_d;
      s2_v_q <= acc;
    end
  end

  always_ff @(posedge clk_i) begin
    tos_q <= tos_d;
    if (acc) begin
      s2_op_q   <= op_e'(op_i);
      s2_arg_q  <= operand_i;
      s2_st_q   <= st;
      s2_kz_q   <= (operand_i == '0);
      s2_dwe_q  <= dwe;
      s2_dwa_q  <= dwa;
      s2_rwe_q  <= rwe;
      s2_rwa_q  <= rwa;
      // same-entry write from the instruction now executing
      s2_dhit_q <= s2_v_q && s2_dwe_q && (s2_dwa_q == dra);
      s2_dbyp_q <= tos_q;
      s2_rhit_q <= s2_v_q && s2_rwe_q && (s2_rwa_q == rra);
      s2_rbyp_q <= ip_inc;
    end
  end

  sms_ram #(
    .WIDTH(WORD_BITS),
    .DEPTH(STACK_DEPTH)
  ) u_data_ram (
    .clk_i  (clk_i),
    .we_i   (s2_v_q && s2_dwe_q),
    .waddr_i(s2_dwa_q),
    .wdata_i(tos_q),
    .raddr_i(dra),
    .rdata_o(d_rdata)
  );

  sms_ram #(
    .WIDTH(IP_W),
    .DEPTH(STACK_DEPTH)
  ) u_ret_ram (
    .clk_i  (clk_i),
    .we_i   (s2_v_q && s2_rwe_q),
    .waddr_i(s2_rwa_q),
    .wdata_i(ip_inc),
    .raddr_i(rra),
    .rdata_o(r_rdata)
  );

  sms_outq u_outq (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (s2_v_q),
    .data_i (res),
    .valid_o(out_valid_o),
    .stall_i(out_stall_i),
    .data_o (q_data),
    .count_o(q_cnt)
  );

  assign status_o      = q_data.status;
  assign next_ip_o     = q_data.next_ip;
  assign halted_flag_o = q_data.halted;
  assign char_valid_o  = q_data.char_valid;
  assign char_out_o    = q_data.char_out;

endmodule

// ===== sv/sms_ram.sv =====
// ----------------------------------------------------------------------------
// sms_ram
// Generic single write, single read RAM with registered read data.
// ----------------------------------------------------------------------------
module sms_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // read returns old data on a same-address write
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ===== sv/sms_outq.sv =====
// ----------------------------------------------------------------------------
// sms_outq
// Small result queue that decouples execution from the output stall.
// ----------------------------------------------------------------------------
module sms_outq
  import sms_pkg::*;
(
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  input  result_t        data_i,
  output logic           valid_o,
  input  logic           stall_i,
  output result_t        data_o,
  output logic [QCW-1:0] count_o
);

  result_t        ent_q [OUTQ_DEPTH];
  logic [QPW-1:0] wr_q, wr_d;
  logic [QPW-1:0] rd_q, rd_d;
  logic [QCW-1:0] cnt_q, cnt_d;
  logic           pop;

  assign valid_o = (cnt_q != '0);
  assign pop     = valid_o && !stall_i;
  assign data_o  = ent_q[rd_q];
  assign count_o = cnt_q;

  always_comb begin
    wr_d  = wr_q;
    rd_d  = rd_q;
    cnt_d = cnt_q;
    if (push_i) begin
      wr_d = (wr_q == QPW'(OUTQ_DEPTH - 1)) ? '0 : wr_q + 1'b1;
    end
    if (pop) begin
      rd_d = (rd_q == QPW'(OUTQ_DEPTH - 1)) ? '0 : rd_q + 1'b1;
    end
    if (push_i && !pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (!push_i && pop) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      ent_q[wr_q] <= data_i;
    end
  end

endmodule

// ===== sv/sms_checker.sv =====
// ----------------------------------------------------------------------------
// sms_checker
// Port-level checks for the stack machine instruction step block.
// ----------------------------------------------------------------------------
module sms_checker
  import sms_pkg::*;
(
  input logic              clk_i,
  input logic              rst_ni,
  input logic              out_valid_o,
  input logic              out_stall_i,
  input logic [ST_W-1:0]   status_o,
  input logic [IP_W-1:0]   next_ip_o,
  input logic              halted_flag_o,
  input logic              char_valid_o,
  input logic [CHAR_W-1:0] char_out_o
);

  logic            beat;
  logic [IP_W-1:0] last_ip_q;
  logic            seen_halt_q;

  assign beat = out_valid_o && !out_stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      last_ip_q   <= '0;
      seen_halt_q <= 1'b0;
    end else if (beat) begin
      last_ip_q   <= next_ip_o;
      seen_halt_q <= seen_halt_q || halted_flag_o;
    end
  end

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o)
    else $error("output valid dropped while stalled");

  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> $stable(status_o) && $stable(next_ip_o)
      && $stable(halted_flag_o) && $stable(char_valid_o) && $stable(char_out_o))
    else $error("stalled output beat changed");

  // a failed step leaves the instruction pointer where the last beat left it
  a_err_keeps_ip: assert property (@(posedge clk_i) disable iff (!rst_ni)
    beat && status_o != ST_OK |-> next_ip_o == last_ip_q && !char_valid_o)
    else $error("error step moved the instruction pointer");

  a_halt_sticky: assert property (@(posedge clk_i) disable iff (!rst_ni)
    beat && seen_halt_q |-> halted_flag_o)
    else $error("halt flag cleared after being set");

  a_char_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    beat && !char_valid_o |-> char_out_o == '0)
    else $error("character byte nonzero without a write");

endmodule

bind stack_machine_instruction_step sms_checker u_sms_checker (.*);
